### design/rmbs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rmbs_pkg
// Shared sizes, codes and state type for the rate monotonic budget scheduler.
// ============================================================================
package rmbs_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_ATTACH = 2'd1,
        MODE_DETACH = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_BUDGET = 2'd1,
        STATUS_EMPTY     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_SWEEP   = 2'd1,
        S_RESOLVE = 2'd2,
        S_DONE    = 2'd3
    } t_state;

endpackage

### design/rate_monotonic_budget_scheduler_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// rate_monotonic_budget_scheduler_unit
// Rate monotonic task scheduler with per-task budgets and deadline-miss flags.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command word: a tick,
//   an attach of a task slot (period and budget) or a detach of a slot.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result word
//   per command: the slot picked to run, status, deadline-miss mask and the
//   preempted / out-of-budget flags of the previous running task.
// Sequencing:
//   A tick, attach or detach walks all MAX_ENTRIES slots, one slot per cycle,
//   through a single reload / compare / decrement unit, then passes through
//   the resolve state before the result is ready. A tick on an empty queue
//   and mode 3 skip the sweep and resolve and go straight to the done state.
//   The block works on one word at a time; o_in_ready is high only when idle,
//   so a new word is not taken before the last one has retired.
// Reset:
//   i_rst_n low clears the attached flags, the running task and the output
//   valid. Task counters need no clearing: they are only read once attached.
// Stall:
//   A finished result sits in the output register. If the receiver stalls,
//   the next command still runs to completion and then waits until the
//   output register frees before it retires.
// ============================================================================
module rate_monotonic_budget_scheduler_unit
    import rmbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [IDX_W-1:0]      i_slot,
    input  logic [DATA_W-1:0]     i_attach_period,
    input  logic [DATA_W-1:0]     i_attach_budget,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IDX_W-1:0]      o_run_slot,
    output logic                  o_run_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [MAX_ENTRIES-1:0] o_deadline_miss_mask,
    output logic                  o_preempted,
    output logic                  o_out_of_budget
);

    // ------------------------------------------------------------------------
    // Task table: attached flags reset, counters written on attach.
    // ------------------------------------------------------------------------
    logic [MAX_ENTRIES-1:0] r_attached;
    logic [DATA_W-1:0]      r_task_period [MAX_ENTRIES];
    logic [DATA_W-1:0]      r_task_budget [MAX_ENTRIES];
    logic [DATA_W-1:0]      r_period_left [MAX_ENTRIES];
    logic [DATA_W-1:0]      r_budget_left [MAX_ENTRIES];
    logic [IDX_W-1:0]       r_queue_rank  [MAX_ENTRIES];

    logic                   r_run_valid;
    logic [IDX_W-1:0]       r_run_slot;

    // ------------------------------------------------------------------------
    // Command word and sequencer
    // ------------------------------------------------------------------------
    t_state                 r_state;
    t_state                 n_state;
    t_mode                  r_mode;
    logic [IDX_W-1:0]       r_slot;
    logic [DATA_W-1:0]      r_period;
    logic [DATA_W-1:0]      r_budget;
    logic                   r_s_att;     // target slot was attached at accept
    logic [IDX_W-1:0]       r_s_rank;    // its rank at accept
    logic [IDX_W-1:0]       r_idx;       // sweep position
    logic [CNT_W-1:0]       r_cnt;       // attached slots other than target

    // Best candidate and running-task snapshot gathered by the sweep
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_slot;
    logic [DATA_W-1:0]      r_best_period;
    logic [IDX_W-1:0]       r_best_rank;
    logic [DATA_W-1:0]      r_best_bl;
    logic [DATA_W-1:0]      r_cur_period;
    logic [DATA_W-1:0]      r_cur_bl;

    // Result staging
    logic [IDX_W-1:0]       r_res_slot;
    logic                   r_res_valid;
    t_status                r_res_status;
    logic [MAX_ENTRIES-1:0] r_res_miss;
    logic                   r_res_pre;
    logic                   r_res_oob;

    // Output register
    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_slot;
    logic                   r_out_run_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [MAX_ENTRIES-1:0] r_out_miss;
    logic                   r_out_pre;
    logic                   r_out_oob;

    logic                   w_accept;
    logic                   w_empty;
    logic                   w_last;
    logic                   w_load_out;
    logic [IDX_W-1:0]       w_rd_idx;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    assign w_accept = i_in_valid && o_in_ready;
    assign w_empty  = ~|r_attached;
    assign w_last   = (r_idx == IDX_W'(MAX_ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((t_mode'(i_mode) == MODE_NONE) ||
                        ((t_mode'(i_mode) == MODE_TICK) && w_empty)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (w_last) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------------
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        // one read port into the rank store: target slot when idle, sweep
        // position otherwise
        w_rd_idx   = (r_state == S_IDLE) ? i_slot : r_idx;
    end

    // ------------------------------------------------------------------------
    // Shared slot unit: reload, budget check, best-candidate compare and
    // period decrement for the slot under r_idx.
    // ------------------------------------------------------------------------
    logic              w_att;
    logic              w_reload;
    logic [DATA_W-1:0] w_pl;
    logic [DATA_W-1:0] w_bl;
    logic              w_miss;
    logic [DATA_W-1:0] w_tp;
    logic [IDX_W-1:0]  w_rank;
    logic              w_better;
    logic              w_is_cur;
    logic              w_shift;
    logic              w_count;

    always_comb begin
        w_att    = r_attached[r_idx];
        w_reload = (r_period_left[r_idx] == '0);
        w_pl     = w_reload ? r_task_period[r_idx] : r_period_left[r_idx];
        w_bl     = w_reload ? r_task_budget[r_idx] : r_budget_left[r_idx];
        w_miss   = w_reload && (r_budget_left[r_idx] != '0);
        w_tp     = r_task_period[r_idx];
        w_rank   = r_queue_rank[w_rd_idx];
        w_better = (w_bl != '0) &&
                   (!r_found || (w_tp < r_best_period) ||
                    ((w_tp == r_best_period) && (w_rank < r_best_rank)));
        w_is_cur = r_run_valid && (r_run_slot == r_idx);
        // close up the attach order behind the target slot
        w_shift  = w_att && r_s_att && (r_idx != r_slot) && (w_rank > r_s_rank);
        w_count  = w_att && (r_idx != r_slot);
    end

    // ------------------------------------------------------------------------
    // Resolve: decide between the running task and the best candidate.
    // ------------------------------------------------------------------------
    logic              w_oob;
    logic              w_pre;
    logic              w_use_cur;
    logic              w_found;
    logic [IDX_W-1:0]  w_pick;
    logic [DATA_W-1:0] w_pick_bl;
    logic              w_hit_run;

    always_comb begin
        w_oob     = r_run_valid && (r_cur_bl == '0);
        w_pre     = r_run_valid && !w_oob && r_found && (r_cur_period > r_best_period);
        w_use_cur = r_run_valid && !w_oob && !w_pre;
        w_found   = r_found || w_use_cur;
        w_pick    = w_use_cur ? r_run_slot : r_best_slot;
        w_pick_bl = w_use_cur ? r_cur_bl : r_best_bl;
        w_hit_run = r_s_att && r_run_valid && (r_run_slot == r_slot);
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_attached  <= '0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_RESOLVE) begin
                if (r_mode == MODE_TICK) begin
                    if (w_found) begin
                        r_run_valid <= 1'b1;
                        r_run_slot  <= w_pick;
                    end else begin
                        r_run_valid <= 1'b0;
                        r_run_slot  <= '0;
                    end
                end else begin
                    // attach or detach: drop the running task if it is the target
                    if (w_hit_run) begin
                        r_run_valid <= 1'b0;
                        r_run_slot  <= '0;
                    end
                    r_attached[r_slot] <= (r_mode == MODE_ATTACH);
                end
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // capture the command word and clear the sweep context
                    r_mode       <= t_mode'(i_mode);
                    r_slot       <= i_slot;
                    r_period     <= i_attach_period;
                    r_budget     <= i_attach_budget;
                    r_s_att      <= r_attached[i_slot];
                    r_s_rank     <= w_rank;
                    r_idx        <= '0;
                    r_cnt        <= '0;
                    r_found      <= 1'b0;
                    r_res_slot   <= '0;
                    r_res_valid  <= 1'b0;
                    r_res_miss   <= '0;
                    r_res_pre    <= 1'b0;
                    r_res_oob    <= 1'b0;
                    r_res_status <= ((t_mode'(i_mode) == MODE_TICK) && w_empty) ?
                                    STATUS_EMPTY : STATUS_OK;
                end
            end
            S_SWEEP: begin
                r_idx <= r_idx + IDX_W'(1);
                if (r_mode == MODE_TICK) begin
                    if (w_att) begin
                        r_period_left[r_idx] <= w_pl - DATA_W'(1);
                        r_budget_left[r_idx] <= w_bl;
                        r_res_miss[r_idx]    <= w_miss;
                        if (w_better) begin
                            r_found       <= 1'b1;
                            r_best_slot   <= r_idx;
                            r_best_period <= w_tp;
                            r_best_rank   <= w_rank;
                            r_best_bl     <= w_bl;
                        end
                        if (w_is_cur) begin
                            r_cur_period <= w_tp;
                            r_cur_bl     <= w_bl;
                        end
                    end
                end else begin
                    if (w_shift) begin
                        r_queue_rank[r_idx] <= w_rank - IDX_W'(1);
                    end
                    if (w_count) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
            end
            S_RESOLVE: begin
                if (r_mode == MODE_TICK) begin
                    r_res_pre <= w_pre;
                    r_res_oob <= w_oob;
                    if (w_found) begin
                        // spend one budget tick on the chosen task
                        r_budget_left[w_pick] <= w_pick_bl - DATA_W'(1);
                        r_res_slot            <= w_pick;
                        r_res_valid           <= 1'b1;
                        r_res_status          <= STATUS_OK;
                    end else begin
                        r_res_status <= STATUS_NO_BUDGET;
                    end
                end else if (r_mode == MODE_ATTACH) begin
                    // load the slot and append it at the tail
                    r_task_period[r_slot] <= r_period;
                    r_task_budget[r_slot] <= r_budget;
                    r_period_left[r_slot] <= r_period;
                    r_budget_left[r_slot] <= r_budget;
                    r_queue_rank[r_slot]  <= r_cnt[IDX_W-1:0];
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    r_out_slot      <= r_res_slot;
                    r_out_run_valid <= r_res_valid;
                    r_out_status    <= r_res_status;
                    r_out_miss      <= r_res_miss;
                    r_out_pre       <= r_res_pre;
                    r_out_oob       <= r_res_oob;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------------
    assign o_out_valid          = r_out_valid;
    assign o_run_slot           = r_out_slot;
    assign o_run_valid          = r_out_run_valid;
    assign o_status             = r_out_status;
    assign o_deadline_miss_mask = r_out_miss;
    assign o_preempted          = r_out_pre;
    assign o_out_of_budget      = r_out_oob;

endmodule

### verif/tb_rate_monotonic_budget_scheduler_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rate_monotonic_budget_scheduler_unit
// Self-checking bench: drives tick, attach and detach words with random
// gaps, mirrors the scheduler state in a local predictor and compares every
// result word field by field, under random and long output back-pressure.
// ============================================================================
module tb_rate_monotonic_budget_scheduler_unit;
    import rmbs_pkg::*;

    localparam int RANDOM_WORDS = 440;   // stop the random part past this count
    localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int STALL_LIMIT  = 2000;  // several times the longest legal quiet stretch
    localparam int TAIL_CYCLES  = 24;    // more than one command's full run through the block
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [IDX_W-1:0]       run_slot;
        logic                   run_valid;
        logic [STATUS_W-1:0]    status;
        logic [MAX_ENTRIES-1:0] miss_mask;
        logic                   preempted;
        logic                   out_of_budget;
    } t_sched_result;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_in_valid      = 1'b0;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      i_mode          = '0;
    logic [IDX_W-1:0]       i_slot          = '0;
    logic [DATA_W-1:0]      i_attach_period = '0;
    logic [DATA_W-1:0]      i_attach_budget = '0;
    logic                   o_out_valid;
    logic                   i_out_ready     = 1'b0;
    logic [IDX_W-1:0]       o_run_slot;
    logic                   o_run_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [MAX_ENTRIES-1:0] o_deadline_miss_mask;
    logic                   o_preempted;
    logic                   o_out_of_budget;

    // predictor copy of the task table
    logic              sched_attached    [MAX_ENTRIES];
    logic [DATA_W-1:0] sched_period      [MAX_ENTRIES];
    logic [DATA_W-1:0] sched_budget      [MAX_ENTRIES];
    logic [DATA_W-1:0] sched_period_left [MAX_ENTRIES];
    logic [DATA_W-1:0] sched_budget_left [MAX_ENTRIES];
    logic [IDX_W-1:0]  sched_rank        [MAX_ENTRIES];
    logic [IDX_W-1:0]  sched_run_slot;
    logic              sched_run_valid;

    t_sched_result pending_decisions[$];
    int            mismatch_count = 0;
    int            words_sent     = 0;
    int            ready_run      = 0;
    bit            no_gaps        = 1'b0;
    logic          hold_active    = 1'b0;
    event          hold_off_go;

    rate_monotonic_budget_scheduler_unit uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_mode               (i_mode),
        .i_slot               (i_slot),
        .i_attach_period      (i_attach_period),
        .i_attach_budget      (i_attach_budget),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_run_slot           (o_run_slot),
        .o_run_valid          (o_run_valid),
        .o_status             (o_status),
        .o_deadline_miss_mask (o_deadline_miss_mask),
        .o_preempted          (o_preempted),
        .o_out_of_budget      (o_out_of_budget)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int count_live();
        int n;
        n = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) n += sched_attached[i] ? 1 : 0;
        return n;
    endfunction

    // remove a slot and close up the attach order behind it
    function automatic void drop_slot(input logic [IDX_W-1:0] s);
        if (!sched_attached[s]) return;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (sched_attached[i] && sched_rank[i] > sched_rank[s])
                sched_rank[i] = sched_rank[i] - IDX_W'(1);
        sched_attached[s] = 1'b0;
        if (sched_run_valid && sched_run_slot == s) begin
            sched_run_valid = 1'b0;
            sched_run_slot  = '0;
        end
    endfunction

    function automatic t_sched_result schedule_next(input t_mode cmd,
                                                    input logic [IDX_W-1:0] s,
                                                    input logic [DATA_W-1:0] period,
                                                    input logic [DATA_W-1:0] budget);
        t_sched_result    r;
        logic             found;
        logic [IDX_W-1:0] pick;
        r     = '0;
        found = 1'b0;
        pick  = '0;
        case (cmd)
            MODE_ATTACH: begin
                drop_slot(s);
                sched_period[s]      = period;
                sched_budget[s]      = budget;
                sched_period_left[s] = period;
                sched_budget_left[s] = budget;
                sched_rank[s]        = IDX_W'(count_live());
                sched_attached[s]    = 1'b1;
            end
            MODE_DETACH: begin
                drop_slot(s);
            end
            MODE_TICK: begin
                if (count_live() == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (sched_attached[i]) begin
                            // reload at period end, flag unspent budget
                            if (sched_period_left[i] == '0) begin
                                if (sched_budget_left[i] != '0) r.miss_mask[i] = 1'b1;
                                sched_budget_left[i] = sched_budget[i];
                                sched_period_left[i] = sched_period[i];
                            end
                            if (sched_budget_left[i] != '0 &&
                                (!found || sched_period[i] < sched_period[pick] ||
                                 (sched_period[i] == sched_period[pick] &&
                                  sched_rank[i] < sched_rank[pick]))) begin
                                pick  = IDX_W'(i);
                                found = 1'b1;
                            end
                            sched_period_left[i] = sched_period_left[i] - DATA_W'(1);
                        end
                    end
                    // the running task holds on unless drained or strictly beaten
                    if (sched_run_valid) begin
                        if (sched_budget_left[sched_run_slot] == '0) begin
                            r.out_of_budget = 1'b1;
                        end else if (found &&
                                     sched_period[sched_run_slot] > sched_period[pick]) begin
                            r.preempted = 1'b1;
                        end else begin
                            pick  = sched_run_slot;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        sched_run_slot          = pick;
                        sched_run_valid         = 1'b1;
                        sched_budget_left[pick] = sched_budget_left[pick] - DATA_W'(1);
                        r.run_slot              = pick;
                        r.run_valid             = 1'b1;
                    end else begin
                        sched_run_valid = 1'b0;
                        sched_run_slot  = '0;
                        r.status        = STATUS_NO_BUDGET;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_word(input t_mode cmd, input logic [IDX_W-1:0] slot_idx,
                             input logic [DATA_W-1:0] period,
                             input logic [DATA_W-1:0] budget);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 50) gap = 0;
        else if (pick < 85)       gap = $urandom_range(1, 3);
        else if (pick < 97)       gap = $urandom_range(4, 10);
        else                      gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= cmd;
        i_slot          <= slot_idx;
        i_attach_period <= period;
        i_attach_budget <= budget;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_decisions.push_back(schedule_next(cmd, slot_idx, period, budget));
        words_sent++;
    endtask

    // tick with junk in the unused fields
    task automatic send_tick();
        send_word(MODE_TICK, IDX_W'($urandom), $urandom, $urandom);
    endtask

    // drop valid and hold until every result word has come back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_decisions.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] random_period();
        if ($urandom_range(0, 99) < 6) return $urandom;
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [DATA_W-1:0] random_budget(input logic [DATA_W-1:0] period);
        if ($urandom_range(0, 99) < 6) return $urandom;
        if (period > 16) return $urandom_range(0, 16);
        return $urandom_range(0, period + 1);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random ready runs, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : long_hold
        forever begin
            @(hold_off_go);
            hold_active <= 1'b1;
            repeat (LONG_HOLD) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_sink
        int pick;
        if (!i_rst_n || hold_active) begin
            i_out_ready <= 1'b0;
            ready_run = 0;
        end else if (ready_run > 0) begin
            ready_run--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                i_out_ready <= 1'b1;
                ready_run = $urandom_range(0, 6);
            end else if (pick < 65) begin
                i_out_ready <= 1'b1;
                ready_run = $urandom_range(20, 60);
            end else if (pick < 93) begin
                i_out_ready <= 1'b0;
                ready_run = $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_run = $urandom_range(10, 40);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch("result word with nothing pending", 0, 0);
            end else begin
                want = pending_decisions.pop_front();
                if (o_run_slot !== want.run_slot)
                    report_mismatch("run_slot", 32'(want.run_slot), 32'(o_run_slot));
                if (o_run_valid !== want.run_valid)
                    report_mismatch("run_valid", 32'(want.run_valid), 32'(o_run_valid));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_deadline_miss_mask !== want.miss_mask)
                    report_mismatch("deadline_miss_mask", 32'(want.miss_mask),
                                    32'(o_deadline_miss_mask));
                if (o_preempted !== want.preempted)
                    report_mismatch("preempted", 32'(want.preempted), 32'(o_preempted));
                if (o_out_of_budget !== want.out_of_budget)
                    report_mismatch("out_of_budget", 32'(want.out_of_budget),
                                    32'(o_out_of_budget));
            end
        end
    end

    // end the run if no word moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_commands();
        send_tick();                                   // empty queue
        send_word(MODE_NONE, '1, '1, '1);
        send_word(MODE_DETACH, IDX_W'(3), '0, '0);     // slot not attached
    endtask

    task automatic test_longest_period();
        send_word(MODE_ATTACH, IDX_W'(7), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick();
    endtask

    task automatic test_preempt_and_exhaust();
        send_word(MODE_ATTACH, IDX_W'(0), 32'd4, 32'd1);
        send_tick();                                   // shorter period takes over
        send_tick();                                   // its single tick is spent
    endtask

    task automatic test_tie_and_reattach();
        send_word(MODE_ATTACH, IDX_W'(2), 32'd4, 32'd2);
        send_tick();
        send_word(MODE_ATTACH, IDX_W'(0), 32'd4, 32'd2);   // moves to the tail
        send_tick();
    endtask

    task automatic test_detach_running();
        send_word(MODE_DETACH, sched_run_slot, '0, '0);
        send_tick();
    endtask

    task automatic test_deadline_miss();
        send_word(MODE_ATTACH, IDX_W'(1), 32'd1, 32'd3);
        send_tick();
        send_tick();
    endtask

    task automatic test_period_zero();
        send_word(MODE_ATTACH, IDX_W'(5), 32'd0, 32'd2);
        send_tick();
    endtask

    task automatic test_no_budget();
        for (int s = 0; s < MAX_ENTRIES; s++)
            if (sched_attached[s]) send_word(MODE_DETACH, IDX_W'(s), '0, '0);
        send_word(MODE_ATTACH, IDX_W'(4), 32'd2, 32'd0);
        send_tick();
        send_tick();
    endtask

    // stall the receiver while ticks keep coming, then let everything drain
    task automatic test_output_backpressure();
        send_word(MODE_ATTACH, IDX_W'(3), 32'd5, 32'd2);
        send_word(MODE_ATTACH, IDX_W'(6), 32'd3, 32'd1);
        -> hold_off_go;
        no_gaps = 1'b1;
        repeat (10) send_tick();
        no_gaps = 1'b0;
        wait_for_drain();
    endtask

    // episodes: attach a few tasks, run ticks with churn, then tear down
    task automatic test_random_schedule();
        int               pick;
        logic [DATA_W-1:0] period;
        logic [IDX_W-1:0] s;
        while (words_sent < RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 5)) begin
                period = random_period();
                send_word(MODE_ATTACH, IDX_W'($urandom), period, random_budget(period));
            end
            repeat ($urandom_range(8, 40)) begin
                pick = $urandom_range(0, 99);
                if (pick < 82) begin
                    send_tick();
                end else if (pick < 89) begin
                    period = random_period();
                    send_word(MODE_ATTACH, IDX_W'($urandom), period, random_budget(period));
                end else if (pick < 95) begin
                    send_word(MODE_DETACH, IDX_W'($urandom), $urandom, $urandom);
                end else if (pick < 97) begin
                    send_word(MODE_NONE, IDX_W'($urandom), $urandom, $urandom);
                end else if (sched_run_valid) begin
                    send_word(MODE_DETACH, sched_run_slot, $urandom, $urandom);
                end
            end
            if ($urandom_range(0, 99) < 30) begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (sched_attached[i]) send_word(MODE_DETACH, IDX_W'(i), '0, '0);
                send_tick();
            end else begin
                repeat ($urandom_range(1, 2)) begin
                    s = IDX_W'($urandom);
                    send_word(MODE_DETACH, s, $urandom, $urandom);
                end
            end
            no_gaps = 1'b0;
            if ($urandom_range(0, 3) == 0) wait_for_drain();
        end
    endtask

    initial begin : main_sequence
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            sched_attached[i]    = 1'b0;
            sched_period[i]      = '0;
            sched_budget[i]      = '0;
            sched_period_left[i] = '0;
            sched_budget_left[i] = '0;
            sched_rank[i]        = '0;
        end
        sched_run_slot  = '0;
        sched_run_valid = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_longest_period();
        test_preempt_and_exhaust();
        test_tie_and_reattach();
        test_detach_running();
        test_deadline_miss();
        test_period_zero();
        test_no_budget();
        test_output_backpressure();
        test_random_schedule();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_decisions.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
